/* hw/rtl/tlc_pkg.sv */
// Shared types, constants and a helper for the two-level LRU cache timing block.
// Used by two_level_lru_cache_timing.
package tlc_pkg;

	localparam int ICACHE_SETS_DEF = 64;
	localparam int ICACHE_WAYS_DEF = 4;
	localparam int DCACHE_SETS_DEF = 64;
	localparam int DCACHE_WAYS_DEF = 4;
	localparam int L2_SETS_DEF     = 256;
	localparam int L2_WAYS_DEF     = 8;

	localparam int ADDR_W  = 32;
	localparam int TOTAL_W = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
	} in_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] access_time;
		logic               l1_hit;
		logic [1:0]         l2_outcome;
	} out_t;

	typedef enum logic [1:0] {
		L2_NONE = 2'd0,
		L2_HIT  = 2'd1,
		L2_MISS = 2'd2
	} l2_outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ICACHE_HIT = 3'd0,
		CFG_DCACHE_HIT = 3'd1,
		CFG_L2_HIT     = 3'd2,
		CFG_MEM_LAT    = 3'd3,
		CFG_INCLUSIVE  = 3'd4,
		CFG_OFFSET     = 3'd5,
		CFG_IPRESENT   = 3'd6,
		CFG_DPRESENT   = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_LOOK,
		ST_BRD,
		ST_BINV,
		ST_RDF,
		ST_FILL,
		ST_OUT
	} state_t;

	// floor(log2(n)) for elaboration-time sizing
	function automatic int floor_log2(input int n);
		int b;
		int v;
		b = 0;
		v = n;
		while (v > 1) begin
			v = v >> 1;
			b = b + 1;
		end
		return b;
	endfunction

endpackage

/* hw/rtl/tlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlc_ram #(
	parameter int W = 8,
	parameter int D = 2,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hw/rtl/tlc_set_ops.sv */
// Set operations on one cache row: lookup, LRU touch, fill and invalidate.
// Row layout per way: {rank, valid, tag}. No package dependencies.
module tlc_set_ops #(
	parameter int WAYS = 4,
	parameter int TW = 26,
	localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1,
	localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1,
	localparam int EW = TW + 1 + RW,
	localparam int ROWW = WAYS * EW
) (
	input  logic [ROWW-1:0] row,
	input  logic [TW-1:0]   tag,
	input  logic [TW-1:0]   fill_tag,
	output logic            hit,
	output logic            full,
	output logic [TW-1:0]   victim_tag,
	output logic [ROWW-1:0] row_touch,
	output logic [ROWW-1:0] row_fill,
	output logic [ROWW-1:0] row_inval
);
	logic [TW-1:0] tg [WAYS];
	logic          vl [WAYS];
	logic [RW-1:0] rk [WAYS];
	logic [WI-1:0] hw;
	logic [WI-1:0] fw;
	logic [WI-1:0] inv_w;
	logic [WI-1:0] lru_w;
	logic [RW-1:0] top;
	logic          any_inv;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			tg[w] = row[w*EW +: TW];
			vl[w] = row[w*EW + TW];
			rk[w] = row[w*EW + TW + 1 +: RW];
		end
	end

	// first matching valid way, first invalid way, first way of highest rank
	always_comb begin
		hw = '0;
		hit = 1'b0;
		inv_w = '0;
		any_inv = 1'b0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vl[w] && tg[w] == tag) begin
				hw = WI'(w);
				hit = 1'b1;
			end
			if (!vl[w]) begin
				inv_w = WI'(w);
				any_inv = 1'b1;
			end
		end
		top = '0;
		lru_w = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rk[w] > top) begin
				top = rk[w];
				lru_w = WI'(w);
			end
		end
		full = !any_inv;
		fw = any_inv ? inv_w : lru_w;
		victim_tag = tg[fw];
	end

	always_comb begin
		row_touch = row;
		row_fill = row;
		row_inval = row;
		for (int v = 0; v < WAYS; v++) begin
			if (WI'(v) != hw && vl[v] && rk[v] < rk[hw]) begin
				row_touch[v*EW + TW + 1 +: RW] = rk[v] + RW'(1);
			end
			if (WI'(v) != fw && vl[v] && (!vl[fw] || rk[v] < rk[fw])) begin
				row_fill[v*EW + TW + 1 +: RW] = rk[v] + RW'(1);
			end
			if (WI'(v) != hw && vl[v] && rk[v] > rk[hw]) begin
				row_inval[v*EW + TW + 1 +: RW] = rk[v] - RW'(1);
			end
		end
		row_touch[hw*EW + TW + 1 +: RW] = '0;
		row_touch[hw*EW + TW] = 1'b1;
		row_fill[fw*EW +: TW] = fill_tag;
		row_fill[fw*EW + TW + 1 +: RW] = '0;
		row_fill[fw*EW + TW] = 1'b1;
		row_inval[hw*EW + TW + 1 +: RW] = '0;
		row_inval[hw*EW + TW] = 1'b0;
	end
endmodule

/* hw/rtl/two_level_lru_cache_timing.sv */
// Top level: sequencer, configuration registers and the three cache row stores.
// Depends on tlc_pkg, tlc_ram and tlc_set_ops.
//
// Usage: an access beat (op, addr) enters on in_valid/in_ready; one result beat
// (access_time, l1_hit, l2_outcome) leaves on out_valid/out_ready. One access
// is handled at a time; in_ready is high only while the block is idle.
// Steps: out_valid rises after read, lookup and result when no back-invalidation
// runs; when an L2 eviction back-invalidates the L1s, the old L1 set is then read
// and invalidated; and when the L1 is enabled its own set is then re-read and filled.
// The lookup, invalidate and fill steps each wait on one registered read of the
// row stores.
// The result stays on out_data while out_ready is low; no new access is taken
// until it is delivered.
// Configuration beats on cfg_valid/cfg_ready are always taken; write them only
// while the block is idle.
// Reset: configuration takes its defaults, then a clearing pass writes every
// row of every store with in_ready low.
module two_level_lru_cache_timing #(
	parameter int ICACHE_SETS = tlc_pkg::ICACHE_SETS_DEF,
	parameter int ICACHE_WAYS = tlc_pkg::ICACHE_WAYS_DEF,
	parameter int DCACHE_SETS = tlc_pkg::DCACHE_SETS_DEF,
	parameter int DCACHE_WAYS = tlc_pkg::DCACHE_WAYS_DEF,
	parameter int L2_SETS = tlc_pkg::L2_SETS_DEF,
	parameter int L2_WAYS = tlc_pkg::L2_WAYS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tlc_pkg::in_t                        in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tlc_pkg::out_t                       out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tlc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tlc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tlc_pkg::*;

	localparam int IB_I = floor_log2(ICACHE_SETS);
	localparam int IB_D = floor_log2(DCACHE_SETS);
	localparam int IB_2 = floor_log2(L2_SETS);
	localparam int DEP_I = 1 << IB_I;
	localparam int DEP_D = 1 << IB_D;
	localparam int DEP_2 = 1 << IB_2;
	localparam int TW_I = ADDR_W - IB_I;
	localparam int TW_D = ADDR_W - IB_D;
	localparam int TW_2 = ADDR_W - IB_2;
	localparam int RW_I = (ICACHE_WAYS > 1) ? $clog2(ICACHE_WAYS) : 1;
	localparam int RW_D = (DCACHE_WAYS > 1) ? $clog2(DCACHE_WAYS) : 1;
	localparam int RW_2 = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
	localparam int ROW_I = ICACHE_WAYS * (TW_I + 1 + RW_I);
	localparam int ROW_D = DCACHE_WAYS * (TW_D + 1 + RW_D);
	localparam int ROW_2 = L2_WAYS * (TW_2 + 1 + RW_2);
	localparam int MAXD = (DEP_2 > DEP_I) ? ((DEP_2 > DEP_D) ? DEP_2 : DEP_D)
		: ((DEP_I > DEP_D) ? DEP_I : DEP_D);
	localparam int CW = $clog2(MAXD) + 1;

	state_t state_q, state_d;
	logic [CW-1:0] clr_q;
	logic op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] old_q;
	out_t res_q;

	logic [7:0] ihit_q, dhit_q, l2hit_q;
	logic [9:0] mem_q;
	logic incl_q, ipres_q, dpres_q;
	logic [2:0] off_q;

	// address decode
	logic [ADDR_W-1:0] sh_a, sh_o;
	logic [IB_I-1:0] i_idx_a, i_idx_o;
	logic [IB_D-1:0] d_idx_a, d_idx_o;
	logic [IB_2-1:0] l2_idx_a;
	logic [TW_I-1:0] i_tag_a, i_tag_o;
	logic [TW_D-1:0] d_tag_a, d_tag_o;
	logic [TW_2-1:0] l2_tag_a;

	assign sh_a = addr_q >> off_q;
	assign sh_o = old_q >> off_q;
	assign i_idx_a = sh_a[IB_I-1:0];
	assign i_idx_o = sh_o[IB_I-1:0];
	assign d_idx_a = sh_a[IB_D-1:0];
	assign d_idx_o = sh_o[IB_D-1:0];
	assign l2_idx_a = sh_a[IB_2-1:0];
	assign i_tag_a = sh_a[ADDR_W-1:IB_I];
	assign i_tag_o = sh_o[ADDR_W-1:IB_I];
	assign d_tag_a = sh_a[ADDR_W-1:IB_D];
	assign d_tag_o = sh_o[ADDR_W-1:IB_D];
	assign l2_tag_a = sh_a[ADDR_W-1:IB_2];

	// row stores
	logic i_we, d_we, l2_we;
	logic [IB_I-1:0] i_waddr, i_raddr;
	logic [IB_D-1:0] d_waddr, d_raddr;
	logic [IB_2-1:0] l2_waddr;
	logic [ROW_I-1:0] i_wdata, i_rdata, i_touch, i_fill, i_inval;
	logic [ROW_D-1:0] d_wdata, d_rdata, d_touch, d_fill, d_inval;
	logic [ROW_2-1:0] l2_wdata, l2_rdata, l2_touch, l2_fill, l2_inval;
	logic i_hit, d_hit, l2_hit, i_full, d_full, l2_full;
	logic [TW_I-1:0] i_vtag, i_ltag;
	logic [TW_D-1:0] d_vtag, d_ltag;
	logic [TW_2-1:0] l2_vtag;

	tlc_ram #(.W(ROW_I), .D(DEP_I)) u_iram (
		.clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
		.raddr(i_raddr), .rdata(i_rdata));
	tlc_ram #(.W(ROW_D), .D(DEP_D)) u_dram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata));
	tlc_ram #(.W(ROW_2), .D(DEP_2)) u_l2ram (
		.clk(clk), .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata),
		.raddr(l2_idx_a), .rdata(l2_rdata));

	assign i_ltag = (state_q == ST_BINV) ? i_tag_o : i_tag_a;
	assign d_ltag = (state_q == ST_BINV) ? d_tag_o : d_tag_a;

	tlc_set_ops #(.WAYS(ICACHE_WAYS), .TW(TW_I)) u_iops (
		.row(i_rdata), .tag(i_ltag), .fill_tag(i_tag_a), .hit(i_hit), .full(i_full),
		.victim_tag(i_vtag), .row_touch(i_touch), .row_fill(i_fill), .row_inval(i_inval));
	tlc_set_ops #(.WAYS(DCACHE_WAYS), .TW(TW_D)) u_dops (
		.row(d_rdata), .tag(d_ltag), .fill_tag(d_tag_a), .hit(d_hit), .full(d_full),
		.victim_tag(d_vtag), .row_touch(d_touch), .row_fill(d_fill), .row_inval(d_inval));
	tlc_set_ops #(.WAYS(L2_WAYS), .TW(TW_2)) u_l2ops (
		.row(l2_rdata), .tag(l2_tag_a), .fill_tag(l2_tag_a), .hit(l2_hit), .full(l2_full),
		.victim_tag(l2_vtag), .row_touch(l2_touch), .row_fill(l2_fill), .row_inval(l2_inval));

	logic present, l1_hit_now, binv_go;
	logic [7:0] side_time;
	logic [TOTAL_W-1:0] total_now;
	logic [ADDR_W-1:0] old_now;

	assign present = op_q ? dpres_q : ipres_q;
	assign side_time = op_q ? dhit_q : ihit_q;
	assign l1_hit_now = present && (op_q ? d_hit : i_hit);
	assign binv_go = !l1_hit_now && !l2_hit && l2_full && incl_q;
	assign old_now = {l2_vtag, l2_idx_a} << off_q;
	assign total_now = (present ? TOTAL_W'(side_time) : '0)
		+ (l1_hit_now ? '0 : TOTAL_W'(l2hit_q))
		+ ((l1_hit_now || l2_hit) ? '0 : TOTAL_W'(mem_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == CW'(MAXD - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_RD;
			ST_RD:    state_d = ST_LOOK;
			ST_LOOK:  state_d = binv_go ? ST_BRD : ST_OUT;
			ST_BRD:   state_d = ST_BINV;
			ST_BINV:  state_d = present ? ST_RDF : ST_OUT;
			ST_RDF:   state_d = ST_FILL;
			ST_FILL:  state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		cfg_ready = 1'b1;
	end
	assign out_data = res_q;

	// store read and write control
	always_comb begin
		i_raddr = (state_q == ST_BRD) ? i_idx_o : i_idx_a;
		d_raddr = (state_q == ST_BRD) ? d_idx_o : d_idx_a;
		i_we = 1'b0;
		d_we = 1'b0;
		l2_we = 1'b0;
		i_waddr = i_idx_a;
		d_waddr = d_idx_a;
		l2_waddr = l2_idx_a;
		i_wdata = i_fill;
		d_wdata = d_fill;
		l2_wdata = l2_fill;
		unique case (state_q)
			ST_CLEAR: begin
				i_we = clr_q < CW'(DEP_I);
				d_we = clr_q < CW'(DEP_D);
				l2_we = clr_q < CW'(DEP_2);
				i_waddr = clr_q[IB_I-1:0];
				d_waddr = clr_q[IB_D-1:0];
				l2_waddr = clr_q[IB_2-1:0];
				i_wdata = '0;
				d_wdata = '0;
				l2_wdata = '0;
			end
			ST_LOOK: begin
				if (l1_hit_now) begin
					i_we = !op_q;
					d_we = op_q;
					i_wdata = i_touch;
					d_wdata = d_touch;
				end else begin
					l2_we = 1'b1;
					l2_wdata = l2_hit ? l2_touch : l2_fill;
					// fill L1 now unless back-invalidation must run first
					i_we = present && !op_q && !binv_go;
					d_we = present && op_q && !binv_go;
				end
			end
			ST_BINV: begin
				i_we = i_hit;
				d_we = d_hit;
				i_waddr = i_idx_o;
				d_waddr = d_idx_o;
				i_wdata = i_inval;
				d_wdata = d_inval;
			end
			ST_FILL: begin
				i_we = !op_q;
				d_we = op_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ihit_q <= 8'd1;
			dhit_q <= 8'd1;
			l2hit_q <= 8'd10;
			mem_q <= 10'd100;
			incl_q <= 1'b0;
			off_q <= 3'd5;
			ipres_q <= 1'b1;
			dpres_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CW'(1);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ICACHE_HIT: ihit_q <= cfg_data[7:0];
					CFG_DCACHE_HIT: dhit_q <= cfg_data[7:0];
					CFG_L2_HIT:     l2hit_q <= cfg_data[7:0];
					CFG_MEM_LAT:    mem_q <= cfg_data[9:0];
					CFG_INCLUSIVE:  incl_q <= cfg_data[0];
					CFG_OFFSET:     off_q <= cfg_data[2:0];
					CFG_IPRESENT:   ipres_q <= cfg_data[0];
					CFG_DPRESENT:   dpres_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload: access beat and result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= in_data.op;
			addr_q <= in_data.addr;
		end
		if (state_q == ST_LOOK) begin
			old_q <= old_now;
			res_q.access_time <= total_now;
			res_q.l1_hit <= l1_hit_now;
			res_q.l2_outcome <= l1_hit_now ? L2_NONE : (l2_hit ? L2_HIT : L2_MISS);
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and result both open");
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_RD) else $error("accept did not start read");
	a_hit_no_l2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.l1_hit |-> out_data.l2_outcome == L2_NONE)
		else $error("L1 hit reported an L2 access");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready) else $error("access taken during clear");
	a_binv_inclusive: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BINV |-> incl_q) else $error("back-invalidate without inclusion");
endmodule
